/* hw/rtl/cbs_pkg.sv */
// shared types and helpers for the class-wise box suppression unit
`timescale 1ns / 1ps

package cbs_pkg;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [7:0]  cls;
    logic [15:0] score;
  } entry_t;

  localparam logic [15:0] IOU_THRESHOLD_RESET = 16'd29491;

  // extent of an interval, zero when inverted
  function automatic logic [15:0] span(input logic [15:0] lo, input logic [15:0] hi);
    span = (hi > lo) ? (hi - lo) : 16'd0;
  endfunction

  function automatic logic [15:0] max16(input logic [15:0] a, input logic [15:0] b);
    max16 = (a > b) ? a : b;
  endfunction

  function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
    min16 = (a < b) ? a : b;
  endfunction

endpackage

/* hw/rtl/classwise_box_suppression_unit.sv */
// top level: score-ordered box store with greedy per-class suppression
`timescale 1ns / 1ps
// a non-final box is inserted by walking up past each stored box of lower score, shifting it down one place
// final box: insertion, then suppression over each surviving reference and its compared pairs, then the kept boxes out
// one beat per command; busy stays high until the last kept box has been shown
// sequencing is set by the single read port of the box store and the shared multiplier
// rst (synchronous, active high) empties the store and loads the default threshold
// results are one-cycle strobes on kept_valid; the receiver cannot stall them
module classwise_box_suppression_unit
  import cbs_pkg::*;
#(
  parameter int MAX_BOXES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] box_left,
  input  logic [15:0] box_top,
  input  logic [15:0] box_right,
  input  logic [15:0] box_bottom,
  input  logic [7:0]  class_id,
  input  logic [15:0] confidence,
  input  logic        final_box,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output logic        kept_valid,
  output logic [15:0] kept_left,
  output logic [15:0] kept_top,
  output logic [15:0] kept_right,
  output logic [15:0] kept_bottom,
  output logic [7:0]  kept_class,
  output logic [15:0] kept_score,
  output logic        last_kept,
  output logic        overflowed
);

  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int AW = $clog2(MAX_BOXES);
  localparam logic [CW-1:0] CAP = CW'(MAX_BOXES);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_INS_RD   = 12'b000000000010,
    S_INS_CMP  = 12'b000000000100,
    S_SUP_I    = 12'b000000001000,
    S_SUP_LOAD = 12'b000000010000,
    S_SUP_J    = 12'b000000100000,
    S_SUP_SPAN = 12'b000001000000,
    S_SUP_MI   = 12'b000010000000,
    S_SUP_MB   = 12'b000100000000,
    S_SUP_UN   = 12'b001000000000,
    S_SUP_CMP  = 12'b010000000000,
    S_EMIT     = 12'b100000000000
  } state_t;

  state_t state;
  logic   emit_out;   // high once an output read has returned, store data valid

  // box store, one read and one write port, registered read data
  entry_t          store [MAX_BOXES];
  entry_t          rd_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;

  // control and frame state
  logic [CW-1:0]        box_count;
  logic                 overflow_seen;
  logic [MAX_BOXES-1:0] sup_marks;
  logic [15:0]          iou_threshold;
  logic [CW-1:0]        idx_i;
  logic [CW-1:0]        idx_j;
  logic [CW-1:0]        last_idx;
  logic                 frame_end;

  // candidate being inserted
  entry_t new_box;

  // pair datapath
  entry_t      box_a;
  logic [31:0] area_a;
  logic [31:0] area_b;
  logic [31:0] inter;
  logic [32:0] uni;
  logic [15:0] iw, ih, bw, bh;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [48:0] thr_prod;
  logic        too_much;

  assign busy = (state != S_IDLE) || kept_valid;

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      S_SUP_LOAD: begin
        mul_a = {16'd0, span(rd_data.left, rd_data.right)};
        mul_b = {16'd0, span(rd_data.top, rd_data.bottom)};
      end
      S_SUP_MI: begin
        mul_a = {16'd0, iw};
        mul_b = {16'd0, ih};
      end
      S_SUP_MB: begin
        mul_a = {16'd0, bw};
        mul_b = {16'd0, bh};
      end
      S_SUP_CMP: begin
        mul_a = {16'd0, iou_threshold};
        mul_b = uni[31:0];
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  // threshold * union, with the union's top bit folded in by a shift
  assign thr_prod = mul_p[48:0] + {1'b0, (uni[32] ? iou_threshold : 16'd0), 32'd0};
  assign too_much = (uni != 33'd0) && ({1'b0, inter, 16'd0} > thr_prod);

  // store port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = new_box;
    case (state)
      S_INS_RD: begin
        if (idx_i == '0) begin
          wr_en = 1'b1;
          wr_addr = '0;
        end else begin
          rd_en = 1'b1;
          rd_addr = AW'(idx_i - 1'b1);
        end
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        wr_addr = idx_i[AW-1:0];
        // shift the lower-scored box down one place
        if (rd_data.score < new_box.score) wr_data = rd_data;
      end
      S_SUP_I: begin
        rd_en = 1'b1;
        rd_addr = idx_i[AW-1:0];
      end
      S_SUP_J: begin
        rd_en = 1'b1;
        rd_addr = idx_j[AW-1:0];
      end
      S_EMIT: begin
        rd_en = 1'b1;
        rd_addr = idx_i[AW-1:0];
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= wr_data;
    if (rd_en) rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      emit_out      <= 1'b0;
      box_count     <= '0;
      overflow_seen <= 1'b0;
      sup_marks     <= '0;
      iou_threshold <= IOU_THRESHOLD_RESET;
      kept_valid    <= 1'b0;
      idx_i         <= '0;
      idx_j         <= '0;
      last_idx      <= '0;
      frame_end     <= 1'b0;
    end else begin
      kept_valid <= 1'b0;
      if (cfg_wr_en) iou_threshold <= cfg_wr_data;

      case (state)
        S_IDLE: begin
          if (start) begin
            new_box   <= '{left: box_left, top: box_top, right: box_right,
                           bottom: box_bottom, cls: class_id, score: confidence};
            frame_end <= final_box;
            idx_i     <= box_count;
            if (box_count >= CAP) begin
              // store full: drop the box, still close the frame if final
              overflow_seen <= 1'b1;
              if (final_box) begin
                idx_i <= '0;
                state <= S_SUP_I;
              end
            end else begin
              state <= S_INS_RD;
            end
          end
        end

        S_INS_RD: begin
          if (idx_i == '0) begin
            box_count <= box_count + 1'b1;
            state     <= frame_end ? S_SUP_I : S_IDLE;
          end else begin
            state <= S_INS_CMP;
          end
        end

        S_INS_CMP: begin
          if (rd_data.score < new_box.score) begin
            idx_i <= idx_i - 1'b1;
            state <= S_INS_RD;
          end else begin
            box_count <= box_count + 1'b1;
            idx_i     <= '0;
            state     <= frame_end ? S_SUP_I : S_IDLE;
          end
        end

        // outer walk over ranks; a surviving box becomes the reference
        S_SUP_I: begin
          if (idx_i == box_count) begin
            idx_i    <= '0;
            emit_out <= 1'b0;
            state    <= S_EMIT;
          end else if (sup_marks[idx_i[AW-1:0]]) begin
            idx_i <= idx_i + 1'b1;
          end else begin
            last_idx <= idx_i;
            state    <= S_SUP_LOAD;
          end
        end

        S_SUP_LOAD: begin
          box_a  <= rd_data;
          area_a <= mul_p[31:0];
          idx_j  <= idx_i + 1'b1;
          state  <= S_SUP_J;
        end

        // inner walk over lower-ranked boxes
        S_SUP_J: begin
          if (idx_j == box_count) begin
            idx_i <= idx_i + 1'b1;
            state <= S_SUP_I;
          end else if (sup_marks[idx_j[AW-1:0]]) begin
            idx_j <= idx_j + 1'b1;
          end else begin
            state <= S_SUP_SPAN;
          end
        end

        S_SUP_SPAN: begin
          if (rd_data.cls != box_a.cls) begin
            idx_j <= idx_j + 1'b1;
            state <= S_SUP_J;
          end else begin
            iw    <= span(max16(box_a.left, rd_data.left), min16(box_a.right, rd_data.right));
            ih    <= span(max16(box_a.top, rd_data.top), min16(box_a.bottom, rd_data.bottom));
            bw    <= span(rd_data.left, rd_data.right);
            bh    <= span(rd_data.top, rd_data.bottom);
            state <= S_SUP_MI;
          end
        end

        S_SUP_MI: begin
          inter <= mul_p[31:0];
          state <= S_SUP_MB;
        end

        S_SUP_MB: begin
          area_b <= mul_p[31:0];
          state  <= S_SUP_UN;
        end

        S_SUP_UN: begin
          // intersection never exceeds either area, so no wrap
          uni   <= {1'b0, area_a} + {1'b0, area_b} - {1'b0, inter};
          state <= S_SUP_CMP;
        end

        S_SUP_CMP: begin
          if (too_much) sup_marks[idx_j[AW-1:0]] <= 1'b1;
          idx_j <= idx_j + 1'b1;
          state <= S_SUP_J;
        end

        // output walk: a read of the store, then a step that registers the beat
        S_EMIT: begin
          if (emit_out) begin
            kept_valid  <= 1'b1;
            kept_left   <= rd_data.left;
            kept_top    <= rd_data.top;
            kept_right  <= rd_data.right;
            kept_bottom <= rd_data.bottom;
            kept_class  <= rd_data.cls;
            kept_score  <= rd_data.score;
            last_kept   <= (idx_i == last_idx);
            overflowed  <= overflow_seen;
            idx_i       <= idx_i + 1'b1;
            emit_out    <= 1'b0;
          end else if (idx_i == box_count) begin
            box_count     <= '0;
            overflow_seen <= 1'b0;
            sup_marks     <= '0;
            frame_end     <= 1'b0;
            state         <= S_IDLE;
          end else if (sup_marks[idx_i[AW-1:0]]) begin
            idx_i <= idx_i + 1'b1;
          end else begin
            emit_out <= 1'b1;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    box_count <= CAP) else $error("box count beyond capacity");

  // a non-final box dropped on a full store leaves the block idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && ((box_count < CAP) || final_box) |=> busy)
    else $error("accepted command did not raise busy");

  a_beat_from_emit: assert property (@(posedge clk) disable iff (rst)
    kept_valid |-> $past(state == S_EMIT) && $past(emit_out))
    else $error("result beat outside the output walk");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> sup_marks == '0) else $error("suppression marks left over");
`endif

endmodule
